@@ src/itsr_pkg.sv @@
// ============================================================================
// itsr_pkg
// Shared types and codes for the dense ID table with swap-remove.
// ============================================================================
package itsr_pkg;

   // Operation codes as they arrive on the request tuser field.
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   // Field widths fixed by the port format.
   localparam int ID_W   = 32;
   localparam int XF_W   = 16;
   localparam int SLOT_W = 6;
   localparam int OCC_W  = 7;

   // Depth of the command queue between front and back (power of two).
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_LOOKUP,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   entity_id;
      logic [XF_W-1:0]   transform_index;
      logic              press_flag;
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]   assigned_id;
      logic [SLOT_W-1:0] slot_index;
      logic              hit;
      logic [1:0]        status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

@@ src/itsr_front.sv @@
// ============================================================================
// itsr_front
// Request intake: decodes the operation code and pushes a command.
// ============================================================================
module itsr_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [31:0]       req_entity_id,
   input  logic [15:0]       req_transform_index,
   input  logic              req_press_flag,
   output logic              push,
   input  logic              push_ready,
   output itsr_pkg::cmd_type push_cmd
);

   itsr_pkg::op_type op;

   always_comb begin
      case (req_mode)
         itsr_pkg::MODE_ADD:    op = itsr_pkg::OP_ADD;
         itsr_pkg::MODE_REMOVE: op = itsr_pkg::OP_REMOVE;
         itsr_pkg::MODE_LOOKUP: op = itsr_pkg::OP_LOOKUP;
         default:               op = itsr_pkg::OP_NONE;
      endcase
   end

   assign req_ready = push_ready;
   assign push      = req_valid & push_ready;

   assign push_cmd.op              = op;
   assign push_cmd.entity_id       = req_entity_id;
   assign push_cmd.transform_index = req_transform_index;
   assign push_cmd.press_flag      = req_press_flag;

endmodule

@@ src/itsr_queue.sv @@
// ============================================================================
// itsr_queue
// Small command queue decoupling the intake from the table engine.
// ============================================================================
module itsr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  itsr_pkg::cmd_type push_cmd,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output itsr_pkg::cmd_type head_cmd
);

   localparam int PTR_W = $clog2(itsr_pkg::QUEUE_DEPTH);

   itsr_pkg::cmd_type entry_ff [itsr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    fill_ff, fill_in;

   assign push_ready = fill_ff != (PTR_W+1)'(itsr_pkg::QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/itsr_back.sv @@
// ============================================================================
// itsr_back
// Table engine: record memory, live count, ID counter, search and swap
// sequencer, and the result register.
// ============================================================================
module itsr_back #(
   parameter int CAPACITY        = 64,
   parameter int TRANSFORM_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  itsr_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itsr_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [31:0]                id;
      logic [TRANSFORM_WIDTH-1:0] xf;
      logic                       press;
   } rec_type;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DIRECT   = 6'b000010,
      S_SCAN     = 6'b000100,
      S_SWAP_RD  = 6'b001000,
      S_SWAP_WR1 = 6'b010000,
      S_SWAP_WR2 = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   itsr_pkg::cmd_type cmd_ff, cmd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       next_id_ff, next_id_in;
   logic [SLOT_W-1:0] iss_ff, iss_in;
   logic [SLOT_W-1:0] chk_ff, chk_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0] found_ff, found_in;
   rec_type           hold_ff, hold_in;
   rec_type           rd_data_ff;
   rec_type           mem [CAPACITY];

   logic              rsp_valid_ff, rsp_valid_in;
   itsr_pkg::rsp_type rsp_ff;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   rec_type           wr_data;
   logic [SLOT_W-1:0] rd_addr;

   logic              load;
   logic [31:0]       ld_id;
   logic [SLOT_W-1:0] ld_slot;
   logic              ld_hit;
   logic [1:0]        ld_status;
   logic [CNT_W-1:0]  ld_occ;

   logic              match;
   logic              miss;
   logic [SLOT_W-1:0] match_slot;
   logic [CNT_W-1:0]  last_cnt;
   logic [SLOT_W-1:0] last_slot;
   logic [31:0]       id_use;
   logic [31:0]       xf_wide;

   assign last_cnt  = count_ff - CNT_W'(1);
   assign last_slot = last_cnt[SLOT_W-1:0];
   assign id_use    = (count_ff == '0) ? 32'd0 : next_id_ff;
   assign xf_wide   = 32'(head_cmd.transform_index);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      next_id_in = next_id_ff;
      iss_in     = iss_ff;
      chk_in     = chk_ff;
      chk_vld_in = chk_vld_ff;
      found_in   = found_ff;
      hold_in    = hold_ff;
      wr_en      = 1'b0;
      wr_addr    = found_ff;
      wr_data    = rd_data_ff;
      rd_addr    = iss_ff;
      pop        = 1'b0;
      load       = 1'b0;
      ld_id      = '0;
      ld_slot    = '0;
      ld_hit     = 1'b0;
      ld_status  = itsr_pkg::STATUS_OK;
      ld_occ     = count_ff;
      match      = 1'b0;
      miss       = 1'b0;
      match_slot = chk_ff;

      case (state_ff)
         S_IDLE: begin
            if (head_valid && !rsp_valid_ff) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               case (head_cmd.op)
                  itsr_pkg::OP_ADD: begin
                     load = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        ld_status = itsr_pkg::STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = count_ff[SLOT_W-1:0];
                        wr_data.id    = id_use;
                        wr_data.xf    = xf_wide[TRANSFORM_WIDTH-1:0];
                        wr_data.press = head_cmd.press_flag;
                        count_in      = count_ff + CNT_W'(1);
                        next_id_in    = id_use + 32'd1;
                        ld_id         = id_use;
                        ld_slot       = count_ff[SLOT_W-1:0];
                        ld_hit        = 1'b1;
                        ld_occ        = count_in;
                     end
                  end
                  itsr_pkg::OP_REMOVE, itsr_pkg::OP_LOOKUP: begin
                     if (head_cmd.entity_id < 32'(count_ff)) begin
                        rd_addr  = head_cmd.entity_id[SLOT_W-1:0];
                        state_in = S_DIRECT;
                     end else if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = itsr_pkg::STATUS_MISS;
                     end else begin
                        iss_in     = '0;
                        chk_vld_in = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_DIRECT: begin
            if (rd_data_ff.id == cmd_ff.entity_id) begin
               match      = 1'b1;
               match_slot = cmd_ff.entity_id[SLOT_W-1:0];
            end else begin
               iss_in     = '0;
               chk_vld_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chk_vld_ff && rd_data_ff.id == cmd_ff.entity_id) begin
               match      = 1'b1;
               match_slot = chk_ff;
            end else if (chk_vld_ff && CNT_W'(chk_ff) == last_cnt) begin
               miss = 1'b1;
            end else begin
               rd_addr    = iss_ff;
               chk_in     = iss_ff;
               chk_vld_in = 1'b1;
               iss_in     = iss_ff + SLOT_W'(1);
            end
         end
         S_SWAP_RD: begin
            rd_addr  = last_slot;
            state_in = S_SWAP_WR1;
         end
         S_SWAP_WR1: begin
            wr_en    = 1'b1;
            wr_addr  = found_ff;
            wr_data  = rd_data_ff;
            state_in = S_SWAP_WR2;
         end
         S_SWAP_WR2: begin
            wr_en    = 1'b1;
            wr_addr  = last_slot;
            wr_data  = hold_ff;
            count_in = last_cnt;
            load     = 1'b1;
            ld_slot  = found_ff;
            ld_hit   = 1'b1;
            ld_occ   = last_cnt;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (match) begin
         found_in = match_slot;
         hold_in  = rd_data_ff;
         if (cmd_ff.op == itsr_pkg::OP_REMOVE && match_slot != last_slot) begin
            state_in = S_SWAP_RD;
         end else begin
            if (cmd_ff.op == itsr_pkg::OP_REMOVE) begin
               count_in = last_cnt;
            end
            load     = 1'b1;
            ld_slot  = match_slot;
            ld_hit   = 1'b1;
            ld_occ   = count_in;
            state_in = S_IDLE;
         end
      end else if (miss) begin
         load      = 1'b1;
         ld_status = itsr_pkg::STATUS_MISS;
         state_in  = S_IDLE;
      end

      rsp_valid_in = (rsp_valid_ff & ~rsp_ready) | load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_id_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      iss_ff   <= iss_in;
      chk_ff   <= chk_in;
      found_ff <= found_in;
      hold_ff  <= hold_in;
      if (load) begin
         rsp_ff.assigned_id <= ld_id;
         rsp_ff.slot_index  <= itsr_pkg::SLOT_W'(ld_slot);
         rsp_ff.hit         <= ld_hit;
         rsp_ff.status      <= ld_status;
         rsp_ff.occupancy   <= itsr_pkg::OCC_W'(ld_occ);
      end
   end

   // Record memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The live count never passes the table size.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("live count above capacity");

   // Writes land only in a live slot or the slot just past the live range.
   a_write_in_range : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CNT_W'(wr_addr) <= count_ff)
      else $error("record write outside live range");

   // The search only ever compares data read from a live slot.
   a_scan_live : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_vld_ff) |-> CNT_W'(chk_ff) < count_ff)
      else $error("search examined a dead slot");

   // A new result appears only as the engine returns to idle.
   a_result_at_idle : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == S_IDLE)
      else $error("result issued mid-operation");

   // A command is taken only while the result register is free.
   a_pop_free : assert property (@(posedge clock) disable iff (reset)
      pop |-> !rsp_valid_ff && head_valid)
      else $error("command taken while result pending");

endmodule

@@ src/id_table_swap_remove.sv @@
// ============================================================================
// id_table_swap_remove
// Dense record table with automatic ID assignment and swap-remove.
// ============================================================================
// Each request beat carries one operation: add a record (transform index and
// pressable flag) under the next ID from a running counter, remove a record by
// ID, or look up the slot holding an ID. The counter restarts at 0 whenever an
// add finds the table empty, and an add on a full table is refused with the
// full status. Lookups and removes first try the slot whose number equals
// the ID if it is live, then search the live slots from 0 upward; a remove
// moves the last live record into the freed slot. Every request beat yields
// exactly one response beat, in order. A small command queue sits in front
// of the table engine, so request beats are still taken while the engine
// works or a response waits. The engine handles one command at a time
// because all records sit in a single memory with one read port. A remove
// that must move the last record then reads it and writes it into the freed
// slot. The record memory is not cleared after reset; only data from slots
// below the live count is ever used.
module id_table_swap_remove #(
   parameter int CAPACITY        = 64,
   parameter int TRANSFORM_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] entity_id, [47:32] transform_index, [48] press_flag, rest zero
   input  logic [55:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] assigned_id, [37:32] slot_index, [44:38] occupancy, rest zero
   output logic [47:0] rsp_tdata,
   // [0] hit, [2:1] status
   output logic [2:0]  rsp_tuser
);

   logic              push;
   logic              push_ready;
   itsr_pkg::cmd_type push_cmd;
   logic              pop;
   logic              head_valid;
   itsr_pkg::cmd_type head_cmd;
   itsr_pkg::rsp_type rsp_data;

   // Intake decodes the operation and feeds the queue.
   itsr_front u_front (
      .req_valid           (req_tvalid),
      .req_ready           (req_tready),
      .req_mode            (req_tuser),
      .req_entity_id       (req_tdata[31:0]),
      .req_transform_index (req_tdata[47:32]),
      .req_press_flag      (req_tdata[48]),
      .push                (push),
      .push_ready          (push_ready),
      .push_cmd            (push_cmd)
   );

   itsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The engine owns the table and holds the response register.
   itsr_back #(
      .CAPACITY        (CAPACITY),
      .TRANSFORM_WIDTH (TRANSFORM_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {3'b000, rsp_data.occupancy, rsp_data.slot_index,
                       rsp_data.assigned_id};
   assign rsp_tuser = {rsp_data.status, rsp_data.hit};

endmodule
